// File: rtl/clocked_gate_latch_8ch_core_defines.svh
// Assertion macros shared by the gate latch RTL files.
`ifndef CLOCKED_GATE_LATCH_8CH_CORE_DEFINES_SVH
`define CLOCKED_GATE_LATCH_8CH_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define CGL_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("gate latch check failed");
// The consequent must hold in the cycle after the antecedent.
`define CGL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("gate latch check failed");
`else
`define CGL_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define CGL_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: rtl/cgl_pkg.sv
// Shared types and constants of the clocked gate latch.
package cgl_pkg;

    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TOL_SEL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_SHORT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_MID   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_LONG  = 2'd3;

    // Window selector codes; the spare code picks the long window.
    localparam logic [1:0] TOL_SHORT = 2'd0;
    localparam logic [1:0] TOL_MID   = 2'd1;

    // Reset values of the window lengths.
    localparam logic [CFG_DATA_W-1:0] WIN_SHORT_RST = 12'd48;
    localparam logic [CFG_DATA_W-1:0] WIN_MID_RST   = 12'd768;
    localparam logic [CFG_DATA_W-1:0] WIN_LONG_RST  = 12'd3072;

    // Window state seen by every lane during the current request.
    typedef struct packed {
        logic up_open;
        logic down_open;
    } t_win_status;

endpackage

// File: rtl/clocked_gate_latch_8ch_core.sv
// Top level of the clocked gate latch: configuration, lanes and output register.
//
//  Channel   Dir  Handshake               Payload
//  s_axis    in   tvalid / tready         tdata: master, then chan 0 .. CHANNELS-1
//  m_axis    out  tvalid / tready         tdata: gate mask, bit i is channel i
//  cfg       in   i_cfg_we (no wait)      i_cfg_idx, i_cfg_data
//
// The window counters and every lane update at the edge that accepts a request,
// and the gate mask lands in the output register at the same edge, so a result
// appears on m_axis in the cycle after its request.
// One request per cycle is sustained while the output side takes results; the single
// output register sets this figure, and s_axis_tready drops only while that register
// holds a result the output side has not taken.
// Reset (synchronous, active low) clears all channel history, pending flags, gates
// and both windows, and restores the default window lengths.
`include "clocked_gate_latch_8ch_core_defines.svh"

module clocked_gate_latch_8ch_core
    import cgl_pkg::*;
#(
    parameter int CHANNELS    = 8,
    parameter int SAMPLE_BITS = 16,
    parameter int WINDOW_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Fields from bit 0 up: master_sample, chan_sample0 .. chan_sampleN, zero pad.
    input  logic [((CHANNELS+1)*SAMPLE_BITS+7)/8*8-1:0] s_axis_tdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // Fields from bit 0 up: gate_mask, zero pad.
    output logic [(CHANNELS+7)/8*8-1:0] m_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int OUT_W = (CHANNELS + 7) / 8 * 8;

    // Configuration registers.
    logic [1:0]            r_tol_sel;
    logic [CFG_DATA_W-1:0] r_win_short;
    logic [CFG_DATA_W-1:0] r_win_mid;
    logic [CFG_DATA_W-1:0] r_win_long;

    logic [CFG_DATA_W-1:0] win_len;
    logic                  acc;
    t_win_status           win_status;
    logic [CHANNELS-1:0]   n_mask;

    // Output register.
    logic                  r_out_valid;
    logic [CHANNELS-1:0]   r_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol_sel   <= TOL_SHORT;
            r_win_short <= WIN_SHORT_RST;
            r_win_mid   <= WIN_MID_RST;
            r_win_long  <= WIN_LONG_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TOL_SEL:   r_tol_sel   <= i_cfg_data[1:0];
                CFG_WIN_SHORT: r_win_short <= i_cfg_data;
                CFG_WIN_MID:   r_win_mid   <= i_cfg_data;
                CFG_WIN_LONG:  r_win_long  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The spare selector code falls through to the long window.
    always_comb begin
        unique case (r_tol_sel)
            TOL_SHORT: win_len = r_win_short;
            TOL_MID:   win_len = r_win_mid;
            default:   win_len = r_win_long;
        endcase
    end

    // A new request is taken whenever the output register is free or being emptied.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign acc           = s_axis_tvalid && s_axis_tready;

    cgl_window #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .WINDOW_BITS (WINDOW_BITS)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_acc    (acc),
        .i_master (s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_len    (win_len),
        .o_status (win_status)
    );

    // One lane per channel; all lanes see the same window state.
    for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
        cgl_lane #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_acc    (acc),
            .i_sample (s_axis_tdata[(g+1)*SAMPLE_BITS +: SAMPLE_BITS]),
            .i_win    (win_status),
            .o_gate   (n_mask[g])
        );
    end

    // Merge the lane gate bits into one result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (acc) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (acc) begin
            r_mask <= n_mask;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'(r_mask);

    `CGL_ASSERT_NEXT(a_acc_valid, i_clk, i_rst_n, acc, m_axis_tvalid)
    `CGL_ASSERT_SAME(a_stall_cause, i_clk, i_rst_n, !s_axis_tready,
        r_out_valid && !m_axis_tready)
    `CGL_ASSERT_NEXT(a_mask_hold, i_clk, i_rst_n, !acc, $stable(r_mask))

endmodule

// File: rtl/cgl_window.sv
// Master edge detector and the up and down window counters.
`include "clocked_gate_latch_8ch_core_defines.svh"

module cgl_window
    import cgl_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int WINDOW_BITS = 12
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_acc,
    input  logic signed [SAMPLE_BITS-1:0] i_master,
    input  logic [CFG_DATA_W-1:0]        i_len,
    output t_win_status                  o_status
);

    localparam int LW = (WINDOW_BITS > CFG_DATA_W) ? WINDOW_BITS : CFG_DATA_W;
    localparam logic [LW-1:0] WIN_MAX = LW'((64'd1 << WINDOW_BITS) - 64'd1);

    logic signed [SAMPLE_BITS-1:0] r_prev;
    logic [WINDOW_BITS-1:0]        r_up_left;
    logic [WINDOW_BITS-1:0]        r_down_left;
    logic [WINDOW_BITS-1:0]        n_up_left;
    logic [WINDOW_BITS-1:0]        n_down_left;
    logic [WINDOW_BITS-1:0]        len_sat;
    logic [LW-1:0]                 len_ext;
    logic [WINDOW_BITS-1:0]        up_trig;
    logic [WINDOW_BITS-1:0]        down_trig;
    logic                          rise;
    logic                          fall;

    always_comb begin
        len_ext = LW'(i_len);
        len_sat = (len_ext > WIN_MAX) ? WIN_MAX[WINDOW_BITS-1:0]
                                      : len_ext[WINDOW_BITS-1:0];
        rise = i_master > r_prev;
        fall = i_master < r_prev;
        // A retrigger keeps the longer of the remaining and the new time.
        up_trig   = (rise && (len_sat > r_up_left))   ? len_sat : r_up_left;
        down_trig = (fall && (len_sat > r_down_left)) ? len_sat : r_down_left;
        o_status.up_open   = up_trig != '0;
        o_status.down_open = down_trig != '0;
        n_up_left   = o_status.up_open   ? up_trig - 1'b1   : up_trig;
        n_down_left = o_status.down_open ? down_trig - 1'b1 : down_trig;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= '0;
            r_up_left   <= '0;
            r_down_left <= '0;
        end else if (i_acc) begin
            r_prev      <= i_master;
            r_up_left   <= n_up_left;
            r_down_left <= n_down_left;
        end
    end

    `CGL_ASSERT_NEXT(a_up_hold, i_clk, i_rst_n, !i_acc, $stable(r_up_left))
    `CGL_ASSERT_NEXT(a_down_hold, i_clk, i_rst_n, !i_acc, $stable(r_down_left))
    `CGL_ASSERT_NEXT(a_up_count, i_clk, i_rst_n, i_acc && !rise && (r_up_left != '0),
        r_up_left == $past(r_up_left) - 1'b1)

endmodule

// File: rtl/cgl_lane.sv
// One channel lane: edge detection, pending set and clear, gate bit.
`include "clocked_gate_latch_8ch_core_defines.svh"

module cgl_lane
    import cgl_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_acc,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  t_win_status                   i_win,
    output logic                          o_gate
);

    logic signed [SAMPLE_BITS-1:0] r_prev;
    logic r_pend_set;
    logic r_pend_clr;
    logic r_gate;
    logic n_pend_set;
    logic n_pend_clr;
    logic n_gate;
    logic rise;
    logic clr_evt;

    always_comb begin
        rise    = i_sample > r_prev;
        // A fall, or a sample that sits at zero, queues a clear.
        clr_evt = !rise && ((i_sample < r_prev) || ((i_sample == '0) && (r_prev == '0)));
        n_pend_set = r_pend_set | rise;
        n_pend_clr = r_pend_clr | clr_evt;
        n_gate     = r_gate;
        if (i_win.up_open && n_pend_set) begin
            n_gate     = 1'b1;
            n_pend_set = 1'b0;
        end else if (i_win.down_open && n_pend_clr) begin
            n_gate     = 1'b0;
            n_pend_clr = 1'b0;
        end
    end

    assign o_gate = n_gate;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev     <= '0;
            r_pend_set <= 1'b0;
            r_pend_clr <= 1'b0;
            r_gate     <= 1'b0;
        end else if (i_acc) begin
            r_prev     <= i_sample;
            r_pend_set <= n_pend_set;
            r_pend_clr <= n_pend_clr;
            r_gate     <= n_gate;
        end
    end

    `CGL_ASSERT_NEXT(a_gate_hold, i_clk, i_rst_n, !i_acc, $stable(r_gate))
    `CGL_ASSERT_NEXT(a_set_wins, i_clk, i_rst_n, i_acc && i_win.up_open && n_gate && !r_gate,
        !r_pend_set)
    `CGL_ASSERT_SAME(a_no_set_clr, i_clk, i_rst_n, i_acc, !(rise && clr_evt))

endmodule

// File: tb/gate_mask_checker.sv
// Checker for the gate latch: predicts each gate mask and compares it with the output.
`timescale 1ns / 100ps

module gate_mask_checker
    import cgl_pkg::*;
#(
    parameter int CHANNELS    = 8,
    parameter int SAMPLE_BITS = 16,
    parameter int WINDOW_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [((CHANNELS+1)*SAMPLE_BITS+7)/8*8-1:0] i_req_data,
    input  logic                  i_req_valid,
    input  logic                  i_req_ready,
    input  logic [(CHANNELS+7)/8*8-1:0] i_res_data,
    input  logic                  i_res_valid,
    input  logic                  i_res_ready,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_errors,
    output int                    o_pending,
    output int                    o_compared
);

    localparam int REQ_W = ((CHANNELS+1)*SAMPLE_BITS+7)/8*8;

    // Register copies.
    logic [1:0]              win_sel;
    logic [CFG_DATA_W-1:0]   win_short;
    logic [CFG_DATA_W-1:0]   win_mid;
    logic [CFG_DATA_W-1:0]   win_long;

    // Latch state.
    logic signed [SAMPLE_BITS-1:0] last_master;
    logic signed [SAMPLE_BITS-1:0] last_chan [CHANNELS];
    logic [CHANNELS-1:0]           set_waiting;
    logic [CHANNELS-1:0]           clear_waiting;
    logic [CHANNELS-1:0]           gates;
    logic [WINDOW_BITS-1:0]        up_left;
    logic [WINDOW_BITS-1:0]        down_left;

    logic [CHANNELS-1:0] gate_mask_due [$];
    int                  mismatches = 0;
    int                  compared   = 0;
    logic [CHANNELS-1:0] due;
    logic [CHANNELS-1:0] next_mask;

    // Advances the latch state by one frame and returns the gate mask it leaves.
    task automatic latch_frame(input logic [REQ_W-1:0] frame,
                               output logic [CHANNELS-1:0] mask);
        logic [WINDOW_BITS-1:0]        len;
        logic signed [SAMPLE_BITS-1:0] m;
        logic signed [SAMPLE_BITS-1:0] x;
        case (win_sel)
            TOL_SHORT: len = win_short;
            TOL_MID:   len = win_mid;
            default:   len = win_long;
        endcase
        m = frame[SAMPLE_BITS-1:0];
        // A retrigger never shortens a window that is already open.
        if (m > last_master && len > up_left)
            up_left = len;
        if (m < last_master && len > down_left)
            down_left = len;
        last_master = m;
        for (int i = 0; i < CHANNELS; i++) begin
            x = frame[SAMPLE_BITS*(i+1) +: SAMPLE_BITS];
            if (x > last_chan[i])
                set_waiting[i] = 1'b1;
            else if (x < last_chan[i] || (x == 0 && last_chan[i] == 0))
                clear_waiting[i] = 1'b1;
            // The up window wins when both are open and both a set and a clear are waiting.
            if (up_left != 0 && set_waiting[i]) begin
                gates[i]       = 1'b1;
                set_waiting[i] = 1'b0;
            end else if (down_left != 0 && clear_waiting[i]) begin
                gates[i]         = 1'b0;
                clear_waiting[i] = 1'b0;
            end
            last_chan[i] = x;
        end
        if (up_left != 0)
            up_left = up_left - 1'b1;
        if (down_left != 0)
            down_left = down_left - 1'b1;
        mask = gates;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            win_sel       = TOL_SHORT;
            win_short     = WIN_SHORT_RST;
            win_mid       = WIN_MID_RST;
            win_long      = WIN_LONG_RST;
            last_master   = '0;
            set_waiting   = '0;
            clear_waiting = '0;
            gates         = '0;
            up_left       = '0;
            down_left     = '0;
            for (int i = 0; i < CHANNELS; i++)
                last_chan[i] = '0;
            gate_mask_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TOL_SEL:   win_sel   = i_cfg_data[1:0];
                    CFG_WIN_SHORT: win_short = i_cfg_data;
                    CFG_WIN_MID:   win_mid   = i_cfg_data;
                    CFG_WIN_LONG:  win_long  = i_cfg_data;
                    default: ;
                endcase
            end
            // A result leaving at this edge always belongs to an earlier request.
            if (i_res_valid && i_res_ready) begin
                if (gate_mask_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: gate mask %h arrived with none expected",
                             $time, i_res_data[CHANNELS-1:0]);
                end else begin
                    due = gate_mask_due.pop_front();
                    compared++;
                    if (i_res_data[CHANNELS-1:0] !== due) begin
                        mismatches++;
                        $display("%0t: gate mask expected %h, got %h",
                                 $time, due, i_res_data[CHANNELS-1:0]);
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                latch_frame(i_req_data, next_mask);
                gate_mask_due.push_back(next_mask);
            end
        end
        o_errors   <= mismatches;
        o_pending  <= gate_mask_due.size();
        o_compared <= compared;
    end

endmodule

// File: tb/clocked_gate_latch_8ch_core_test.sv
// Top of the gate latch testbench: clock, reset, stimulus, output stalls and verdict.
`timescale 1ns / 100ps

module clocked_gate_latch_8ch_core_test;
    import cgl_pkg::*;

    localparam int CHANNELS    = 8;
    localparam int SAMPLE_BITS = 16;
    localparam int REQ_W       = ((CHANNELS+1)*SAMPLE_BITS+7)/8*8;
    localparam int RES_W       = (CHANNELS+7)/8*8;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 180;
    // The limit leaves room for a correct run even with every
    // sender gap and every receiver stall at its longest.
    localparam int CYCLE_LIMIT = 600000;

    // Selector codes the package does not name: the long window and the
    // spare code, which must also pick the long window.
    localparam logic [1:0] TOL_LONG  = 2'd2;
    localparam logic [1:0] TOL_SPARE = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    // Fields from bit 0 up: master_sample, chan_sample0 .. chan_sample7.
    logic [REQ_W-1:0]      s_axis_tdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // Fields from bit 0 up: gate_mask.
    logic [RES_W-1:0]      m_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int errors;
    int pending;
    int compared;
    int cycles = 0;
    int frames_sent = 0;
    int no_gap_left = 0;
    int ready_left = 0;
    int ready_pick;

    // Current sample levels; random frames mostly hold them or step from them.
    logic signed [SAMPLE_BITS-1:0]   cur_master = '0;
    logic [CHANNELS-1:0][SAMPLE_BITS-1:0] cur_chan = '0;

    clocked_gate_latch_8ch_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    gate_mask_checker i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_data  (s_axis_tdata),
        .i_req_valid (s_axis_tvalid),
        .i_req_ready (s_axis_tready),
        .i_res_data  (m_axis_tdata),
        .i_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_compared  (compared)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("clocked_gate_latch_8ch_core: mismatch");
            $finish;
        end
    end

    // The output side takes results in segments of random length. Most stalls
    // are short, a few are long, and now and then a long stretch runs with no
    // stall at all so back-to-back results are exercised.
    always @(posedge i_clk) begin
        if (ready_left > 0) begin
            ready_left <= ready_left - 1;
        end else begin
            ready_pick = $urandom_range(0, 9);
            if (ready_pick < 5) begin
                m_axis_tready <= 1'b1;
                ready_left    <= $urandom_range(1, 20);
            end else if (ready_pick < 8) begin
                m_axis_tready <= 1'b0;
                ready_left    <= $urandom_range(1, 3);
            end else if (ready_pick < 9) begin
                m_axis_tready <= 1'b0;
                ready_left    <= $urandom_range(10, 40);
            end else begin
                m_axis_tready <= 1'b1;
                ready_left    <= $urandom_range(50, 150);
            end
        end
    end

    // Sends one frame of samples, with an optional idle gap before it, and
    // returns at the edge where the request is accepted.
    task automatic send_samples(input logic [SAMPLE_BITS-1:0] master,
                                input logic [CHANNELS-1:0][SAMPLE_BITS-1:0] chans);
        int gap;
        int pick;
        gap = 0;
        if (no_gap_left > 0) begin
            no_gap_left--;
        end else begin
            pick = $urandom_range(0, 19);
            if (pick >= 12 && pick < 18)
                gap = $urandom_range(1, 3);
            else if (pick == 18)
                gap = $urandom_range(8, 30);
            else if (pick == 19)
                no_gap_left = $urandom_range(30, 100);
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {chans, master};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        frames_sent++;
    endtask

    // Stops sending and waits until every expected gate mask has come out.
    // The first edge lets the checker count a request accepted at this edge.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        // Margin after the last result.
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
    endtask

    // Loads a complete window setting once the block has gone idle.
    task automatic load_windows(input logic [1:0] sel,
                                input logic [CFG_DATA_W-1:0] short_len,
                                input logic [CFG_DATA_W-1:0] mid_len,
                                input logic [CFG_DATA_W-1:0] long_len);
        drain_results();
        write_reg(CFG_TOL_SEL, {{(CFG_DATA_W-2){1'b0}}, sel});
        write_reg(CFG_WIN_SHORT, short_len);
        write_reg(CFG_WIN_MID, mid_len);
        write_reg(CFG_WIN_LONG, long_len);
        i_cfg_we <= 1'b0;
    endtask

    // Sample extremes and the values right around zero.
    function automatic logic [SAMPLE_BITS-1:0] corner_sample(input int n);
        case (n % 5)
            0:       return 16'h0000;
            1:       return 16'h0001;
            2:       return 16'hFFFF;
            3:       return 16'h7FFF;
            default: return 16'h8000;
        endcase
    endfunction

    // A random sample that favors zero, small steps and the extremes, so that
    // rises, falls, zero holds and equal holds all show up often.
    function automatic logic [SAMPLE_BITS-1:0] random_sample();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 3)
            return '0;
        else if (pick < 5)
            return SAMPLE_BITS'($urandom_range(1, 3));
        else if (pick < 6)
            return SAMPLE_BITS'(-$urandom_range(1, 3));
        else if (pick < 7)
            return 16'h7FFF;
        else if (pick < 8)
            return 16'h8000;
        return SAMPLE_BITS'($urandom());
    endfunction

    // Builds the next random frame. The master mostly behaves like a clock
    // toggling between zero and a positive level, which opens up and down
    // windows in turn; channels mostly hold their level like real gates.
    task automatic send_random_frame();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            cur_master = (cur_master > 0) ? '0 : SAMPLE_BITS'($urandom_range(1, 32767));
        else if (pick == 7)
            cur_master = SAMPLE_BITS'($urandom());
        else if (pick == 8)
            cur_master = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        else if (pick == 9)
            cur_master = random_sample();
        for (int k = 0; k < CHANNELS; k++) begin
            if ($urandom_range(0, 99) >= 55)
                cur_chan[k] = random_sample();
        end
        send_samples(cur_master, cur_chan);
    endtask

    initial begin
        // Hold reset with every input at a known value.
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed frames under the reset window setting.
        // A zero hold on every channel queues clears while no window is open.
        send_samples(16'h0000, {CHANNELS{16'h0000}});
        // Master rises: up window opens and every channel rises to full scale.
        send_samples(16'h0064, {CHANNELS{16'h7FFF}});
        // Equal nonzero hold on master and channels changes nothing.
        send_samples(16'h0064, {CHANNELS{16'h7FFF}});
        // Master falls while the up window is still open: both windows open,
        // channels fall to the negative extreme.
        send_samples(16'h8000, {CHANNELS{16'h8000}});
        // Alternating channel rises and holds on a master rise.
        send_samples(16'h7FFF, {(CHANNELS/2){16'h8000, 16'h0001}});
        send_samples(16'h7FFF, {CHANNELS{16'h0000}});
        send_samples(16'h0000, {CHANNELS{16'h0000}});
        // Master swings between its extremes while each channel walks through
        // the corner values, so every channel sees every kind of step.
        for (int j = 0; j < 12; j++) begin
            for (int k = 0; k < CHANNELS; k++)
                cur_chan[k] = corner_sample(j + k);
            cur_master = j[0] ? 16'h7FFF : 16'h8000;
            send_samples(cur_master, cur_chan);
        end

        // Random frames under a series of window settings: the shortest
        // windows, the longest, the spare selector and zero-length windows.
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: load_windows(TOL_SHORT, 12'd1, 12'd2, 12'd3);
                1: load_windows(TOL_MID, 12'd7, 12'd1, 12'd4095);
                2: load_windows(TOL_LONG, 12'd4095, 12'd4095, 12'd2);
                3: load_windows(TOL_SPARE, 12'd5, 12'd9, 12'd1);
                4: load_windows(TOL_SHORT, 12'd0, 12'd5, 12'd6);
                5: load_windows(TOL_MID, 12'd3, 12'd0, 12'd12);
                6: load_windows(TOL_LONG, 12'd2, 12'd3, 12'd0);
                default: load_windows(2'($urandom_range(0, 3)),
                                      12'($urandom_range(0, 8)),
                                      12'($urandom_range(0, 8)),
                                      12'($urandom_range(0, 8)));
            endcase
            repeat (PHASE_ITEMS) send_random_frame();
        end

        drain_results();

        $display("Covered %0d sample frames under %0d window settings after the reset one;",
                 frames_sent, PHASES);
        $display("%0d gate masks were compared against the prediction.", compared);
        if (errors == 0) begin
            $display("clocked_gate_latch_8ch_core: match");
        end else begin
            $display("clocked_gate_latch_8ch_core: mismatch");
        end
        $finish;
    end

endmodule
